[sv/mawf_pkg.sv]
// Package: shared types, register indexes and CORDIC helpers for the angle window filter.
package mawf_pkg;

  typedef enum logic [2:0] {
    CFG_COS      = 3'd0,
    CFG_SIN      = 3'd1,
    CFG_THETA_WIN = 3'd2,
    CFG_PHI_WIN  = 3'd3,
    CFG_MODE     = 3'd4,
    CFG_COUNT    = 3'd5,
    CFG_CODES_LO = 3'd6,
    CFG_CODES_HI = 3'd7
  } cfg_idx_t;

  localparam logic signed [33:0] QUARTER_TURN = 34'sd1073741824;
  localparam logic signed [33:0] HALF_TURN    = 34'sd2147483648;

  typedef struct packed {
    logic               valid;
    logic               zm;
    logic               lok;
    logic [63:0]        rem;
    logic [63:0]        root;
    logic signed [30:0] zv;
    logic signed [30:0] px;
    logic [29:0]        py;
  } sq_t;

  typedef struct packed {
    logic signed [34:0] x;
    logic signed [34:0] y;
    logic signed [33:0] z;
    logic               nul;
  } vec_t;

  typedef struct packed {
    logic valid;
    logic zm;
    logic lok;
    vec_t th;
    vec_t ph;
  } cd_t;

  function automatic logic [29:0] atan_fine(input int i);
    logic [29:0] a;
    case (i)
      0:  a = 30'h20000000;
      1:  a = 30'h12E4051E;
      2:  a = 30'h09FB385B;
      3:  a = 30'h051111D4;
      4:  a = 30'h028B0D43;
      5:  a = 30'h0145D7E1;
      6:  a = 30'h00A2F61E;
      7:  a = 30'h00517C55;
      8:  a = 30'h0028BE53;
      9:  a = 30'h00145F2F;
      10: a = 30'h000A2F98;
      11: a = 30'h000517CC;
      12: a = 30'h00028BE6;
      13: a = 30'h000145F3;
      14: a = 30'h0000A2FA;
      15: a = 30'h0000517D;
      16: a = 30'h000028BE;
      17: a = 30'h0000145F;
      18: a = 30'h00000A30;
      19: a = 30'h00000518;
      20: a = 30'h0000028C;
      21: a = 30'h00000146;
      22: a = 30'h000000A3;
      23: a = 30'h00000051;
      default: a = 30'h0;
    endcase
    return a;
  endfunction

  function automatic logic [39:0] mag41(input logic signed [40:0] v);
    logic signed [40:0] n;
    n = -v;
    return v[40] ? n[39:0] : v[39:0];
  endfunction

  function automatic vec_t pre_rot(input logic signed [34:0] x, input logic signed [34:0] y);
    vec_t r;
    r.nul = (x == 35'sd0) && (y == 35'sd0);
    if (x < 0) begin
      r.x = y;
      r.y = -x;
      r.z = QUARTER_TURN;
    end else begin
      r.x = x;
      r.y = y;
      r.z = 34'sd0;
    end
    return r;
  endfunction

  function automatic vec_t cordic_step(input vec_t v, input int i);
    vec_t r;
    logic signed [34:0] xs;
    logic signed [34:0] ys;
    logic signed [33:0] a;
    xs = v.x >>> i;
    ys = v.y >>> i;
    a = $signed({4'd0, atan_fine(i)});
    r = v;
    if (!v.y[34]) begin
      r.x = v.x + ys;
      r.y = v.y - xs;
      r.z = v.z + a;
    end else begin
      r.x = v.x - ys;
      r.y = v.y + xs;
      r.z = v.z - a;
    end
    return r;
  endfunction

  function automatic logic [15:0] angle_out(input vec_t v);
    logic [31:0] zc;
    logic [32:0] s;
    if (v.z < 0) begin
      zc = 32'd0;
    end else if (v.z > HALF_TURN) begin
      zc = 32'h80000000;
    end else begin
      zc = v.z[31:0];
    end
    s = {1'b0, zc} + 33'd32768;
    return v.nul ? 16'd0 : s[31:16];
  endfunction

endpackage

[sv/mawf_sqrt_cell.sv]
// One cell of the integer square root chain: settles one result bit per cell.
module mawf_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  mawf_pkg::sq_t d,
  output mawf_pkg::sq_t q
);

  localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

  mawf_pkg::sq_t q_r;
  mawf_pkg::sq_t q_nxt;
  logic [63:0]   trial;

  always_comb begin
    q_nxt = d;
    trial = d.root + BIT;
    if (d.rem >= trial) begin
      q_nxt.rem  = d.rem - trial;
      q_nxt.root = (d.root >> 1) + BIT;
    end else begin
      q_nxt.root = d.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.valid <= 1'b0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

[sv/mawf_cordic_cell.sv]
// One CORDIC vectoring cell, turning both the theta and the phi vector.
module mawf_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  mawf_pkg::cd_t d,
  output mawf_pkg::cd_t q
);

  mawf_pkg::cd_t q_r;
  mawf_pkg::cd_t q_nxt;

  always_comb begin
    q_nxt    = d;
    q_nxt.th = mawf_pkg::cordic_step(d.th, STAGE);
    q_nxt.ph = mawf_pkg::cordic_step(d.ph, STAGE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.valid <= 1'b0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

[sv/momentum_angle_window_filter_unit.sv]
// Top level: rotate, normalize, square root and CORDIC chains, window and list test.
//
//  channel | direction | ports
//  in      | input     | in_valid, in_ready, in_mom_x/y/z, in_particle_code
//  out     | output    | out_valid, out_ready, out_accepted, out_zero_momentum,
//          |           | out_polar_angle, out_azimuth_angle
//  cfg     | input     | cfg_we, cfg_index, cfg_wdata
//
// One transfer per cycle while out is not stalled; the chain holds six front stages,
// 32 square root cells, one pre-rotation stage, the CORDIC cells and the output register.
// Synchronous active-low reset empties the chain and loads register defaults.
// A stalled output freezes the whole chain; in_ready falls only while out is stalled.
module momentum_angle_window_filter_unit #(
  parameter int LIST_LEN      = 4,
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [23:0] in_mom_x,
  input  logic signed [23:0] in_mom_y,
  input  logic signed [23:0] in_mom_z,
  input  logic signed [31:0] in_particle_code,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_accepted,
  output logic               out_zero_momentum,
  output logic [15:0]        out_polar_angle,
  output logic [15:0]        out_azimuth_angle,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_wdata
);

  logic signed [15:0] cos_r, sin_r;
  logic [31:0]        thw_r, phw_r;
  logic               mode_r;
  logic [2:0]         count_r;
  logic [63:0]        clo_r, chi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_r   <= 16'sd31795;
      sin_r   <= 16'sd7927;
      thw_r   <= 32'h80000000;
      phw_r   <= 32'hFFFF0000;
      mode_r  <= 1'b1;
      count_r <= 3'd0;
      clo_r   <= 64'd0;
      chi_r   <= 64'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        mawf_pkg::CFG_COS:       cos_r   <= cfg_wdata[15:0];
        mawf_pkg::CFG_SIN:       sin_r   <= cfg_wdata[15:0];
        mawf_pkg::CFG_THETA_WIN: thw_r   <= cfg_wdata[31:0];
        mawf_pkg::CFG_PHI_WIN:   phw_r   <= cfg_wdata[31:0];
        mawf_pkg::CFG_MODE:      mode_r  <= cfg_wdata[0];
        mawf_pkg::CFG_COUNT:     count_r <= cfg_wdata[2:0];
        mawf_pkg::CFG_CODES_LO:  clo_r   <= cfg_wdata;
        mawf_pkg::CFG_CODES_HI:  chi_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic adv;
  logic out_valid_r;
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // list test
  logic [2:0]  n_cnt;
  logic [31:0] entry [4];
  logic        found, lok;
  assign n_cnt    = (count_r > 3'(LIST_LEN)) ? 3'(LIST_LEN) : count_r;
  assign entry[0] = clo_r[31:0];
  assign entry[1] = clo_r[63:32];
  assign entry[2] = chi_r[31:0];
  assign entry[3] = chi_r[63:32];
  always_comb begin
    found = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if ((3'(k) < n_cnt) && (entry[k] == in_particle_code)) found = 1'b1;
    end
    lok = mode_r ? found : !found;
  end

  // stage 1: products
  logic               s1_valid_r, s1_zm_r, s1_lok_r;
  logic signed [23:0] s1_mx_r, s1_my_r, s1_mz_r;
  logic signed [39:0] s1_xc_r, s1_zs_r, s1_xs_r, s1_zc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_zm_r  <= (in_mom_x == 24'sd0) && (in_mom_y == 24'sd0) && (in_mom_z == 24'sd0);
      s1_lok_r <= lok;
      s1_mx_r  <= in_mom_x;
      s1_my_r  <= in_mom_y;
      s1_mz_r  <= in_mom_z;
      s1_xc_r  <= 40'(in_mom_x) * 40'(cos_r);
      s1_zs_r  <= 40'(in_mom_z) * 40'(sin_r);
      s1_xs_r  <= 40'(in_mom_x) * 40'(sin_r);
      s1_zc_r  <= 40'(in_mom_z) * 40'(cos_r);
    end
  end

  // stage 2: rotation sums and magnitudes
  logic signed [40:0] vx, vz, vmx, vmy, vmz;
  logic [39:0]        m_nxt [6];
  assign vx  = 41'(s1_xc_r) - 41'(s1_zs_r);
  assign vz  = 41'(s1_xs_r) + 41'(s1_zc_r);
  assign vmx = 41'(s1_mx_r) <<< 15;
  assign vmy = 41'(s1_my_r) <<< 15;
  assign vmz = 41'(s1_mz_r) <<< 15;
  assign m_nxt[0] = mawf_pkg::mag41(vx);
  assign m_nxt[1] = mawf_pkg::mag41(vmy);
  assign m_nxt[2] = mawf_pkg::mag41(vz);
  assign m_nxt[3] = mawf_pkg::mag41(vmx);
  assign m_nxt[4] = mawf_pkg::mag41(vmy);
  assign m_nxt[5] = mawf_pkg::mag41(vmz);

  logic        s2_valid_r, s2_zm_r, s2_lok_r;
  logic [39:0] s2_mag_r [6];
  logic        s2_xneg_r, s2_zneg_r;
  logic [39:0] s2_or_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_zm_r   <= s1_zm_r;
      s2_lok_r  <= s1_lok_r;
      s2_xneg_r <= vx[40];
      s2_zneg_r <= vz[40];
      s2_or_r   <= m_nxt[0] | m_nxt[1] | m_nxt[2] | m_nxt[3] | m_nxt[4] | m_nxt[5];
      for (int k = 0; k < 6; k++) s2_mag_r[k] <= m_nxt[k];
    end
  end

  // stage 3: common shift
  logic [3:0] sh;
  always_comb begin
    sh = 4'd0;
    for (int k = 0; k < 10; k++) begin
      if (s2_or_r[30 + k]) sh = 4'(k + 1);
    end
  end

  logic        s3_valid_r, s3_zm_r, s3_lok_r, s3_xneg_r, s3_zneg_r;
  logic [29:0] s3_red_r [6];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s3_valid_r <= s2_valid_r;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_zm_r   <= s2_zm_r;
      s3_lok_r  <= s2_lok_r;
      s3_xneg_r <= s2_xneg_r;
      s3_zneg_r <= s2_zneg_r;
      for (int k = 0; k < 6; k++) s3_red_r[k] <= 30'(s2_mag_r[k] >> sh);
    end
  end

  // stage 4: squares
  logic               s4_valid_r, s4_zm_r, s4_lok_r;
  logic [59:0]        s4_sq_r [4];
  logic signed [30:0] s4_x_r, s4_z_r;
  logic [29:0]        s4_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (adv) begin
      s4_valid_r <= s3_valid_r;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s4_zm_r    <= s3_zm_r;
      s4_lok_r   <= s3_lok_r;
      s4_sq_r[0] <= {30'd0, s3_red_r[3]} * {30'd0, s3_red_r[3]};
      s4_sq_r[1] <= {30'd0, s3_red_r[4]} * {30'd0, s3_red_r[4]};
      s4_sq_r[2] <= {30'd0, s3_red_r[5]} * {30'd0, s3_red_r[5]};
      s4_sq_r[3] <= {30'd0, s3_red_r[2]} * {30'd0, s3_red_r[2]};
      s4_x_r     <= s3_xneg_r ? -$signed({1'b0, s3_red_r[0]}) : $signed({1'b0, s3_red_r[0]});
      s4_z_r     <= s3_zneg_r ? -$signed({1'b0, s3_red_r[2]}) : $signed({1'b0, s3_red_r[2]});
      s4_y_r     <= s3_red_r[1];
    end
  end

  // stage 5: sum of squares
  logic               s5_valid_r, s5_zm_r, s5_lok_r;
  logic [61:0]        s5_p2_r;
  logic [59:0]        s5_z2_r;
  logic signed [30:0] s5_x_r, s5_z_r;
  logic [29:0]        s5_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_valid_r <= 1'b0;
    end else if (adv) begin
      s5_valid_r <= s4_valid_r;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s5_zm_r  <= s4_zm_r;
      s5_lok_r <= s4_lok_r;
      s5_p2_r  <= 62'(s4_sq_r[0]) + 62'(s4_sq_r[1]) + 62'(s4_sq_r[2]);
      s5_z2_r  <= s4_sq_r[3];
      s5_x_r   <= s4_x_r;
      s5_z_r   <= s4_z_r;
      s5_y_r   <= s4_y_r;
    end
  end

  // stage 6: transverse square, enters the root chain
  mawf_pkg::sq_t sq_s [33];
  mawf_pkg::sq_t sq0_r;
  mawf_pkg::sq_t sq0_nxt;

  always_comb begin
    sq0_nxt.valid = s5_valid_r;
    sq0_nxt.zm    = s5_zm_r;
    sq0_nxt.lok   = s5_lok_r;
    sq0_nxt.rem   = (62'(s5_z2_r) >= s5_p2_r) ? 64'd0 : 64'(s5_p2_r - 62'(s5_z2_r));
    sq0_nxt.root  = 64'd0;
    sq0_nxt.zv    = s5_z_r;
    sq0_nxt.px    = s5_x_r;
    sq0_nxt.py    = s5_y_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq0_r.valid <= 1'b0;
    end else if (adv) begin
      sq0_r <= sq0_nxt;
    end
  end

  assign sq_s[0] = sq0_r;

  for (genvar k = 0; k < 32; k++) begin : g_sqrt
    mawf_sqrt_cell #(.STEP(k)) u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .en   (adv),
      .d    (sq_s[k]),
      .q    (sq_s[k + 1])
    );
  end

  // pre-rotation
  mawf_pkg::cd_t cd_s [CORDIC_STAGES + 1];
  mawf_pkg::cd_t cd0_r;
  mawf_pkg::cd_t cd0_nxt;

  always_comb begin
    cd0_nxt.valid = sq_s[32].valid;
    cd0_nxt.zm    = sq_s[32].zm;
    cd0_nxt.lok   = sq_s[32].lok;
    cd0_nxt.th    = mawf_pkg::pre_rot(35'(sq_s[32].zv), $signed(sq_s[32].root[34:0]));
    cd0_nxt.ph    = mawf_pkg::pre_rot(35'(sq_s[32].px), $signed({5'd0, sq_s[32].py}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cd0_r.valid <= 1'b0;
    end else if (adv) begin
      cd0_r <= cd0_nxt;
    end
  end

  assign cd_s[0] = cd0_r;

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
    mawf_cordic_cell #(.STAGE(k)) u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .en   (adv),
      .d    (cd_s[k]),
      .q    (cd_s[k + 1])
    );
  end

  // output stage
  mawf_pkg::cd_t fin;
  logic [15:0]   theta, phi;
  logic          acc;
  assign fin   = cd_s[CORDIC_STAGES];
  assign theta = 16'd32768 - mawf_pkg::angle_out(fin.th);
  assign phi   = mawf_pkg::angle_out(fin.ph);
  assign acc   = (theta >= thw_r[15:0]) && (theta <= thw_r[31:16]) &&
                 (phi >= phw_r[15:0]) && (phi <= phw_r[31:16]) && fin.lok;

  logic        acc_r, zm_r;
  logic [15:0] theta_r, phi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= fin.valid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      acc_r   <= fin.zm ? 1'b0 : acc;
      zm_r    <= fin.zm;
      theta_r <= fin.zm ? 16'd0 : theta;
      phi_r   <= fin.zm ? 16'd0 : phi;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_accepted      = acc_r;
  assign out_zero_momentum = zm_r;
  assign out_polar_angle   = theta_r;
  assign out_azimuth_angle = phi_r;

endmodule

[sv/mawf_checker.sv]
// Port-level checker for the angle window filter, bound to the top level.
module mawf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_accepted,
  input logic        out_zero_momentum,
  input logic [15:0] out_polar_angle,
  input logic [15:0] out_azimuth_angle
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_polar_angle))
    else $error("output dropped before transfer");

  a_zero_rejects: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_momentum |-> !out_accepted &&
      out_polar_angle == 16'd0 && out_azimuth_angle == 16'd0)
    else $error("zero momentum result not cleared");

  a_theta_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_polar_angle <= 16'd32768)
    else $error("polar angle beyond half turn");

  a_phi_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_azimuth_angle <= 16'd32768)
    else $error("azimuth beyond half turn");

endmodule

bind momentum_angle_window_filter_unit mawf_checker u_mawf_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_accepted     (out_accepted),
  .out_zero_momentum(out_zero_momentum),
  .out_polar_angle  (out_polar_angle),
  .out_azimuth_angle(out_azimuth_angle)
);

[verif/momentum_angle_window_filter_unit_tb.sv]
// Self-checking testbench for the momentum angle window filter: random and directed hits.
module momentum_angle_window_filter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIST_LEN = 4;
  localparam int CORDIC_STAGES = 16;
  localparam int DRAIN_CYCLES = 60;
  localparam longint QT_FINE = 64'sd1073741824;
  localparam longint HT_FINE = 64'sd2147483648;

  typedef struct {
    bit          acc;
    bit          zm;
    logic [15:0] polar;
    logic [15:0] azim;
  } hit_result_t;

  class hit_scoreboard;
    logic signed [15:0] rot_cos = 16'sd31795;
    logic signed [15:0] rot_sin = 16'sd7927;
    logic [31:0] theta_win = 32'h80000000;
    logic [31:0] phi_win = 32'hFFFF0000;
    bit          keep_mode = 1'b1;
    logic [2:0]  code_count = 3'd0;
    logic [31:0] codes [4] = '{default: 32'd0};
    hit_result_t pending [$];
    int          errors = 0;

    function void write_reg(mawf_pkg::cfg_idx_t idx, logic [63:0] d);
      case (idx)
        mawf_pkg::CFG_COS:       rot_cos = d[15:0];
        mawf_pkg::CFG_SIN:       rot_sin = d[15:0];
        mawf_pkg::CFG_THETA_WIN: theta_win = d[31:0];
        mawf_pkg::CFG_PHI_WIN:   phi_win = d[31:0];
        mawf_pkg::CFG_MODE:      keep_mode = d[0];
        mawf_pkg::CFG_COUNT:     code_count = d[2:0];
        mawf_pkg::CFG_CODES_LO: begin
          codes[0] = d[31:0];
          codes[1] = d[63:32];
        end
        mawf_pkg::CFG_CODES_HI: begin
          codes[2] = d[31:0];
          codes[3] = d[63:32];
        end
        default: ;
      endcase
    endfunction

    function logic [15:0] binary_angle(longint y, longint x);
      longint z, t, xs, ys;
      z = 0;
      if (x == 0 && y == 0) return 16'd0;
      if (x < 0) begin
        t = x;
        x = y;
        y = -t;
        z = QT_FINE;
      end
      for (int i = 0; i < CORDIC_STAGES; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + longint'(mawf_pkg::atan_fine(i));
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - longint'(mawf_pkg::atan_fine(i));
        end
      end
      if (z < 0) z = 0;
      if (z > HT_FINE) z = HT_FINE;
      return 16'((z + 32768) >>> 16);
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function void note_hit(logic signed [23:0] mx, logic signed [23:0] my,
                           logic signed [23:0] mz, logic [31:0] code);
      hit_result_t r;
      longint v [6];
      longint unsigned mmax, p2, z2, h, a;
      int sh, n;
      bit found;
      logic [15:0] th, ph;
      if (mx == 0 && my == 0 && mz == 0) begin
        r = '{acc: 0, zm: 1, polar: 16'd0, azim: 16'd0};
        pending.push_back(r);
        return;
      end
      v[0] = longint'(mx) * longint'(rot_cos) - longint'(mz) * longint'(rot_sin);
      v[1] = longint'(my) * 32768;
      v[2] = longint'(mx) * longint'(rot_sin) + longint'(mz) * longint'(rot_cos);
      v[3] = longint'(mx) * 32768;
      v[4] = v[1];
      v[5] = longint'(mz) * 32768;
      mmax = 0;
      for (int k = 0; k < 6; k++) begin
        a = (v[k] < 0) ? longint'(-v[k]) : v[k];
        if (a > mmax) mmax = a;
      end
      sh = 0;
      while ((mmax >> sh) >= (64'd1 << 30)) sh++;
      for (int k = 0; k < 6; k++)
        v[k] = (v[k] < 0) ? -((-v[k]) >>> sh) : (v[k] >>> sh);
      p2 = v[3] * v[3] + v[4] * v[4] + v[5] * v[5];
      z2 = v[2] * v[2];
      h = int_sqrt((z2 >= p2) ? 64'd0 : p2 - z2);
      th = 16'd32768 - binary_angle(longint'(h), v[2]);
      ph = binary_angle((v[1] < 0) ? -v[1] : v[1], v[0]);
      n = (code_count > LIST_LEN) ? LIST_LEN : code_count;
      found = 0;
      for (int k = 0; k < n; k++)
        if (codes[k] == code) found = 1;
      r.zm = 0;
      r.polar = th;
      r.azim = ph;
      r.acc = (th >= theta_win[15:0]) && (th <= theta_win[31:16]) &&
              (ph >= phi_win[15:0]) && (ph <= phi_win[31:16]) &&
              (keep_mode ? found : !found);
      pending.push_back(r);
    endfunction

    function void check_hit(bit acc, bit zm, logic [15:0] pol, logic [15:0] azi);
      hit_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result transfer", $time);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (acc !== e.acc) begin
        $display("%0t: accepted exp %0d got %0d", $time, e.acc, acc);
        errors++;
      end
      if (zm !== e.zm) begin
        $display("%0t: zero_momentum exp %0d got %0d", $time, e.zm, zm);
        errors++;
      end
      if (pol !== e.polar) begin
        $display("%0t: polar_angle exp %0d got %0d", $time, e.polar, pol);
        errors++;
      end
      if (azi !== e.azim) begin
        $display("%0t: azimuth_angle exp %0d got %0d", $time, e.azim, azi);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [23:0] in_mom_x = '0, in_mom_y = '0, in_mom_z = '0;
  logic signed [31:0] in_particle_code = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_accepted, out_zero_momentum;
  logic [15:0] out_polar_angle, out_azimuth_angle;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = 3'd0;
  logic [63:0] cfg_wdata = '0;

  hit_scoreboard sb = new();
  bit no_idle = 0;
  bit hold_req = 0;
  int hold_left = 0;

  momentum_angle_window_filter_unit #(.LIST_LEN(LIST_LEN), .CORDIC_STAGES(CORDIC_STAGES)) dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_mom_x, .in_mom_y, .in_mom_z, .in_particle_code,
    .out_valid, .out_ready, .out_accepted, .out_zero_momentum, .out_polar_angle,
    .out_azimuth_angle, .cfg_we, .cfg_index, .cfg_wdata);

  always #4 clk = ~clk;

  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready)
        sb.check_hit(out_accepted, out_zero_momentum, out_polar_angle, out_azimuth_angle);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 0;
        hold_left = 300;
        out_ready <= 1'b0;
      end else begin
        out_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 25);
      end
    end
  end

  task automatic write_reg(mawf_pkg::cfg_idx_t idx, logic [63:0] d);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, d);
  endtask

  task automatic send_hit(logic signed [23:0] mx, logic signed [23:0] my,
                          logic signed [23:0] mz, logic [31:0] code);
    if (!no_idle) begin
      while ($urandom_range(99) < 25) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_mom_x <= mx;
    in_mom_y <= my;
    in_mom_z <= mz;
    in_particle_code <= code;
    do @(posedge clk); while (!in_ready);
    sb.note_hit(mx, my, mz, code);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [23:0] rand_comp();
    int sel;
    sel = $urandom_range(99);
    if (sel < 10) return 24'sd0;
    if (sel < 20) return $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
    if (sel < 45) return 24'($signed($urandom_range(511)) - 256);
    return 24'($urandom);
  endfunction

  task automatic send_random(int count);
    logic [31:0] code;
    for (int i = 0; i < count; i++) begin
      code = ($urandom_range(1)) ? sb.codes[$urandom_range(3)] : $urandom;
      send_hit(rand_comp(), rand_comp(), rand_comp(), code);
    end
  endtask

  task automatic random_config();
    logic [31:0] lo, hi;
    write_reg(mawf_pkg::CFG_COS, 64'($urandom));
    write_reg(mawf_pkg::CFG_SIN, 64'($urandom));
    lo = $urandom_range(16384);
    hi = $urandom_range(32768, 16384);
    write_reg(mawf_pkg::CFG_THETA_WIN, {32'd0, hi[15:0], lo[15:0]});
    lo = $urandom_range(16384);
    hi = $urandom_range(32768, 16384);
    write_reg(mawf_pkg::CFG_PHI_WIN, {32'd0, hi[15:0], lo[15:0]});
    write_reg(mawf_pkg::CFG_MODE, 64'($urandom_range(1)));
    write_reg(mawf_pkg::CFG_COUNT, 64'($urandom_range(7)));
    write_reg(mawf_pkg::CFG_CODES_LO, {$urandom, $urandom});
    write_reg(mawf_pkg::CFG_CODES_HI, {$urandom, $urandom});
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_hit(24'sd0, 24'sd0, 24'sd0, 32'd0);
    send_hit(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 32'h7FFFFFFF);
    send_hit(24'sh800000, 24'sh800000, 24'sh800000, 32'h80000000);
    send_hit(24'sd1, 24'sd0, 24'sd0, 32'd0);
    send_hit(24'sd0, 24'sd1, 24'sd0, 32'd0);
    send_hit(24'sd0, 24'sd0, 24'sd1, 32'd0);
    send_hit(24'sd0, 24'sd0, -24'sd1, 32'd0);
    send_hit(-24'sd1000, 24'sd5, 24'sd3, 32'hFFFFFFFF);
    drain();

    write_reg(mawf_pkg::CFG_COS, 64'h7FFF);
    write_reg(mawf_pkg::CFG_SIN, 64'h0);
    write_reg(mawf_pkg::CFG_THETA_WIN, 64'hFFFF0000);
    write_reg(mawf_pkg::CFG_PHI_WIN, 64'hFFFF0000);
    write_reg(mawf_pkg::CFG_MODE, 64'd0);
    write_reg(mawf_pkg::CFG_COUNT, 64'd0);
    write_reg(mawf_pkg::CFG_CODES_LO, 64'h0000000B_FFFFFFF5);
    write_reg(mawf_pkg::CFG_CODES_HI, 64'h80000000_7FFFFFFF);
    send_hit(24'sd0, 24'sd0, 24'sd1234, 32'd11);
    send_hit(24'sd0, 24'sd0, -24'sd1234, 32'd11);
    send_hit(24'sh7FFFFF, 24'sd0, 24'sd0, 32'd5);
    send_hit(24'sh800000, 24'sh7FFFFF, 24'sd0, 32'd5);
    no_idle = 1;
    send_random(200);
    no_idle = 0;
    drain();

    write_reg(mawf_pkg::CFG_COS, 64'h8000);
    write_reg(mawf_pkg::CFG_SIN, 64'h8000);
    write_reg(mawf_pkg::CFG_MODE, 64'd1);
    write_reg(mawf_pkg::CFG_COUNT, 64'd4);
    send_hit(24'sh7FFFFF, 24'sd0, 24'sh7FFFFF, 32'h7FFFFFFF);
    send_hit(24'sd77, 24'sd3, 24'sd77, 32'hFFFFFFF5);
    hold_req = 1;
    send_random(240);
    drain();

    write_reg(mawf_pkg::CFG_THETA_WIN, 64'h0000FFFF);
    write_reg(mawf_pkg::CFG_COUNT, 64'd7);
    send_random(120);
    drain();

    for (int p = 0; p < 6; p++) begin
      random_config();
      send_random(230);
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
